>>> rtl/pwm_channel_allocator_defines.svh
// Assertion macros used by the port-level checker of the PWM channel allocator.
// Depends on nothing; included by the checker.
`ifndef PWM_CHANNEL_ALLOCATOR_DEFINES_SVH
`define PWM_CHANNEL_ALLOCATOR_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define PCA_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PCA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> rtl/pwm_ca_pkg.sv
// Types, codes and constants of the PWM channel allocator.
// Depends on nothing; used by the allocation logic and the top level.
package pwm_ca_pkg;

	localparam int PIN_COUNT_DEF = 64;
	localparam int SIMPLE_CHANNELS_DEF = 8;
	localparam int SIMPLE_IDX_W = 4;

	localparam int MOTOR_UNITS = 2;
	localparam int MOTOR_TIMERS = 3;
	localparam int MOTOR_OPS = 2;
	localparam int MOTOR_SLOTS = MOTOR_UNITS * MOTOR_TIMERS * MOTOR_OPS;

	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_SIMPLE = 2'd1;
	localparam logic [1:0] MODE_MOTOR = 2'd2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PIN_BUSY = 2'd1,
		ST_NO_CHANNEL = 2'd2
	} status_t;

	typedef struct packed {
		logic [5:0] pin_number;
		logic [1:0] driver_mode;
		logic pref_simple_valid;
		logic [7:0] pref_simple_channel;
		logic [1:0] pref_motor_unit;
		logic [1:0] pref_motor_timer;
		logic pref_motor_operator;
	} req_t;

	typedef struct packed {
		status_t status;
		logic driver_used;
		logic [2:0] simple_channel;
		logic motor_unit;
		logic [1:0] motor_timer;
		logic motor_operator;
	} res_t;

endpackage

>>> rtl/pwm_channel_allocator.sv
// Top level of the PWM channel allocator: input register, used maps, result register.
// Depends on pwm_ca_pkg and pwm_ca_alloc.
//
// Requests arrive on the s_axis channel, one word per request, and each request
// produces exactly one result word on the m_axis channel, in request order.
// A request is registered at the edge that accepts it; the allocation decision
// is made from that register against the used-pin, simple-channel and
// motor-slot maps, and the result is loaded into the result register when it
// is empty or its word is being taken.
// Throughput is one request per cycle while results are taken: the maps are updated
// at the same edge that loads the result, so the next request sees the prior grants.
// When the receiver holds m_axis_tready low the result register keeps its word,
// the input register keeps one more request, and s_axis_tready drops only when
// both are full; no word is lost or repeated.
// Reset clears both valid flags and all three maps, so every pin, channel and
// slot is free afterwards. Nothing is ever released except by reset.
module pwm_channel_allocator #(
	parameter int PIN_COUNT = pwm_ca_pkg::PIN_COUNT_DEF,
	parameter int SIMPLE_CHANNELS = pwm_ca_pkg::SIMPLE_CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// pin_number[5:0], pref_simple_valid[6], pref_simple_channel[14:7],
	// pref_motor_unit[16:15], pref_motor_timer[18:17], pref_motor_operator[19]
	input logic [23:0] s_axis_tdata,
	// driver_mode[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[1:0], simple_channel[4:2], motor_unit[5], motor_timer[7:6],
	// motor_operator[8]
	output logic [15:0] m_axis_tdata,
	// driver_used[0]
	output logic m_axis_tuser
);

	pwm_ca_pkg::req_t req_in, req_s1;
	pwm_ca_pkg::res_t res_comb, res_s2;
	logic valid_s1, valid_s2;
	logic adv;

	logic [PIN_COUNT-1:0] pin_map_q, pin_map_nxt;
	logic [SIMPLE_CHANNELS-1:0] simple_map_q, simple_map_nxt;
	logic [pwm_ca_pkg::MOTOR_SLOTS-1:0] motor_map_q, motor_map_nxt;

	assign req_in.pin_number = s_axis_tdata[5:0];
	assign req_in.driver_mode = s_axis_tuser;
	assign req_in.pref_simple_valid = s_axis_tdata[6];
	assign req_in.pref_simple_channel = s_axis_tdata[14:7];
	assign req_in.pref_motor_unit = s_axis_tdata[16:15];
	assign req_in.pref_motor_timer = s_axis_tdata[18:17];
	assign req_in.pref_motor_operator = s_axis_tdata[19];

	assign adv = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	pwm_ca_alloc #(
		.PIN_COUNT(PIN_COUNT),
		.SIMPLE_CHANNELS(SIMPLE_CHANNELS)
	) u_alloc (
		.req(req_s1),
		.pin_map(pin_map_q),
		.simple_map(simple_map_q),
		.motor_map(motor_map_q),
		.res(res_comb),
		.pin_map_nxt(pin_map_nxt),
		.simple_map_nxt(simple_map_nxt),
		.motor_map_nxt(motor_map_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pin_map_q <= '0;
			simple_map_q <= '0;
			motor_map_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				pin_map_q <= pin_map_nxt;
				simple_map_q <= simple_map_nxt;
				motor_map_q <= motor_map_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1 <= req_in;
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = {7'd0, res_s2.motor_operator, res_s2.motor_timer,
		res_s2.motor_unit, res_s2.simple_channel, res_s2.status};
	assign m_axis_tuser = res_s2.driver_used;

endmodule

>>> rtl/pwm_ca_alloc.sv
// Allocation decision for one request against the current used maps.
// Depends on pwm_ca_pkg; instantiated by pwm_channel_allocator.
module pwm_ca_alloc #(
	parameter int PIN_COUNT = pwm_ca_pkg::PIN_COUNT_DEF,
	parameter int SIMPLE_CHANNELS = pwm_ca_pkg::SIMPLE_CHANNELS_DEF
) (
	input pwm_ca_pkg::req_t req,
	input logic [PIN_COUNT-1:0] pin_map,
	input logic [SIMPLE_CHANNELS-1:0] simple_map,
	input logic [pwm_ca_pkg::MOTOR_SLOTS-1:0] motor_map,
	output pwm_ca_pkg::res_t res,
	output logic [PIN_COUNT-1:0] pin_map_nxt,
	output logic [SIMPLE_CHANNELS-1:0] simple_map_nxt,
	output logic [pwm_ca_pkg::MOTOR_SLOTS-1:0] motor_map_nxt
);

	localparam int SLOTS = pwm_ca_pkg::MOTOR_SLOTS;
	localparam int TO = pwm_ca_pkg::MOTOR_TIMERS * pwm_ca_pkg::MOTOR_OPS;

	logic [PIN_COUNT-1:0] pin_oh;
	logic pin_free;

	logic [SIMPLE_CHANNELS-1:0] s_pref_oh, s_free, s_low, s_grant;
	logic s_ok;
	logic [pwm_ca_pkg::SIMPLE_IDX_W-1:0] s_idx;

	logic [SLOTS-1:0] m_pref_oh, m_free, m_low, m_grant;
	logic m_ok;
	logic m_unit, m_op;
	logic [1:0] m_timer;

	logic use_simple, use_motor;

	always_comb begin
		for (int i = 0; i < PIN_COUNT; i++) begin
			pin_oh[i] = (req.pin_number == 6'(i));
		end
		pin_free = (|pin_oh) && !(|(pin_oh & pin_map));

		for (int i = 0; i < SIMPLE_CHANNELS; i++) begin
			s_pref_oh[i] = req.pref_simple_valid && (req.pref_simple_channel == 8'(i));
		end
		s_free = ~simple_map;
		s_low = s_free & (~s_free + SIMPLE_CHANNELS'(1));
		s_grant = (|(s_pref_oh & s_free)) ? s_pref_oh : s_low;
		s_ok = |s_free;
		s_idx = '0;
		for (int i = 0; i < SIMPLE_CHANNELS; i++) begin
			if (s_grant[i]) begin
				s_idx = s_idx | pwm_ca_pkg::SIMPLE_IDX_W'(i);
			end
		end

		m_pref_oh = '0;
		for (int u = 0; u < pwm_ca_pkg::MOTOR_UNITS; u++) begin
			for (int t = 0; t < pwm_ca_pkg::MOTOR_TIMERS; t++) begin
				for (int o = 0; o < pwm_ca_pkg::MOTOR_OPS; o++) begin
					m_pref_oh[u * TO + t * pwm_ca_pkg::MOTOR_OPS + o] =
						(req.pref_motor_unit == 2'(u)) &&
						(req.pref_motor_timer == 2'(t)) &&
						(req.pref_motor_operator == 1'(o));
				end
			end
		end
		m_free = ~motor_map;
		m_low = m_free & (~m_free + SLOTS'(1));
		m_grant = (|(m_pref_oh & m_free)) ? m_pref_oh : m_low;
		m_ok = |m_free;
		m_unit = 1'b0;
		m_timer = 2'd0;
		m_op = 1'b0;
		for (int u = 0; u < pwm_ca_pkg::MOTOR_UNITS; u++) begin
			for (int t = 0; t < pwm_ca_pkg::MOTOR_TIMERS; t++) begin
				for (int o = 0; o < pwm_ca_pkg::MOTOR_OPS; o++) begin
					if (m_grant[u * TO + t * pwm_ca_pkg::MOTOR_OPS + o]) begin
						m_unit = m_unit | 1'(u);
						m_timer = m_timer | 2'(t);
						m_op = m_op | 1'(o);
					end
				end
			end
		end

		use_simple = s_ok && (req.driver_mode != pwm_ca_pkg::MODE_MOTOR);
		use_motor = !use_simple && m_ok && (req.driver_mode != pwm_ca_pkg::MODE_SIMPLE);

		res = '0;
		pin_map_nxt = pin_map;
		simple_map_nxt = simple_map;
		motor_map_nxt = motor_map;
		if (!pin_free) begin
			res.status = pwm_ca_pkg::ST_PIN_BUSY;
		end else if (use_simple) begin
			res.status = pwm_ca_pkg::ST_OK;
			res.simple_channel = s_idx[2:0];
			simple_map_nxt = simple_map | s_grant;
			pin_map_nxt = pin_map | pin_oh;
		end else if (use_motor) begin
			res.status = pwm_ca_pkg::ST_OK;
			res.driver_used = 1'b1;
			res.motor_unit = m_unit;
			res.motor_timer = m_timer;
			res.motor_operator = m_op;
			motor_map_nxt = motor_map | m_grant;
			pin_map_nxt = pin_map | pin_oh;
		end else begin
			res.status = pwm_ca_pkg::ST_NO_CHANNEL;
		end
	end

endmodule

>>> rtl/pwm_ca_checker.sv
// Port-level checker of the PWM channel allocator and its bind to the top level.
// Depends on pwm_channel_allocator_defines.svh.
`include "pwm_channel_allocator_defines.svh"

module pwm_ca_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tuser
);

	`PCA_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !m_axis_tvalid, "result word during reset")
	`PCA_ASSERT(a_hold_stalled, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
	`PCA_ASSERT(a_fail_clean, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0) |-> (m_axis_tdata[15:2] == 14'd0) && !m_axis_tuser && (m_axis_tdata[1:0] != 2'd3), "failed result carries grant fields or bad status")
	`PCA_ASSERT(a_simple_clean, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd0) && !m_axis_tuser |-> m_axis_tdata[8:5] == 4'd0, "simple grant carries motor fields")
	`PCA_ASSERT(a_motor_clean, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd0) && m_axis_tuser |-> (m_axis_tdata[4:2] == 3'd0) && (m_axis_tdata[7:6] != 2'd3), "motor grant has bad fields")

endmodule

bind pwm_channel_allocator pwm_ca_checker u_pwm_ca_checker (.*);

>>> tb/pwm_channel_allocator_checker.sv
// Checker for the PWM channel allocator: watches both stream channels, predicts each grant
// from its own copy of the pin, simple-channel and motor-slot maps, and compares every field.
// Depends on pwm_ca_pkg for the request codes, status codes and result type.
module pwm_grant_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tuser,
	output int fail_count,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int S_CH = pwm_ca_pkg::SIMPLE_CHANNELS_DEF;
	localparam int M_UNITS = pwm_ca_pkg::MOTOR_UNITS;
	localparam int M_TIMERS = pwm_ca_pkg::MOTOR_TIMERS;
	localparam int M_OPS = pwm_ca_pkg::MOTOR_OPS;
	localparam int M_SLOTS = pwm_ca_pkg::MOTOR_SLOTS;

	logic [S_CH-1:0] simple_taken;
	logic [M_SLOTS-1:0] motor_taken;
	logic [pwm_ca_pkg::PIN_COUNT_DEF-1:0] pin_taken;
	pwm_ca_pkg::res_t grant_queue[$];
	pwm_ca_pkg::res_t want;

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input int got, input int wanted);
		if (fail_count < 20) begin
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, wanted);
		end
		fail_count++;
	endtask

	function automatic bit take_simple(input logic psv, input logic [7:0] psc,
			output logic [2:0] chan);
		int k;
		chan = '0;
		if (psv && int'(psc) < S_CH && !simple_taken[psc]) begin
			simple_taken[psc] = 1'b1;
			chan = psc[2:0];
			return 1'b1;
		end
		for (k = 0; k < S_CH; k++) begin
			if (!simple_taken[k]) begin
				simple_taken[k] = 1'b1;
				chan = 3'(k);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit take_motor(input logic [1:0] unit, input logic [1:0] timer,
			input logic op, output int slot);
		int k;
		slot = 0;
		if (int'(unit) < M_UNITS && int'(timer) < M_TIMERS) begin
			k = int'(unit) * M_TIMERS * M_OPS + int'(timer) * M_OPS + int'(op);
			if (!motor_taken[k]) begin
				motor_taken[k] = 1'b1;
				slot = k;
				return 1'b1;
			end
		end
		for (k = 0; k < M_SLOTS; k++) begin
			if (!motor_taken[k]) begin
				motor_taken[k] = 1'b1;
				slot = k;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic pwm_ca_pkg::res_t decide_grant(input logic [5:0] pin,
			input logic [1:0] mode, input logic psv, input logic [7:0] psc,
			input logic [1:0] unit, input logic [1:0] timer, input logic op);
		pwm_ca_pkg::res_t r;
		logic [2:0] chan;
		int slot;
		bit ok;
		bit motor;
		r = '0;
		chan = '0;
		slot = 0;
		ok = 1'b0;
		motor = 1'b0;
		if (int'(pin) >= pwm_ca_pkg::PIN_COUNT_DEF || pin_taken[pin]) begin
			r.status = pwm_ca_pkg::ST_PIN_BUSY;
			return r;
		end
		case (mode)
			pwm_ca_pkg::MODE_SIMPLE: begin
				ok = take_simple(psv, psc, chan);
			end
			pwm_ca_pkg::MODE_MOTOR: begin
				ok = take_motor(unit, timer, op, slot);
				motor = ok;
			end
			default: begin
				ok = take_simple(psv, psc, chan);
				if (!ok) begin
					ok = take_motor(unit, timer, op, slot);
					motor = ok;
				end
			end
		endcase
		if (!ok) begin
			r.status = pwm_ca_pkg::ST_NO_CHANNEL;
			return r;
		end
		pin_taken[pin] = 1'b1;
		r.status = pwm_ca_pkg::ST_OK;
		if (motor) begin
			r.driver_used = 1'b1;
			r.motor_unit = 1'(slot / (M_TIMERS * M_OPS));
			r.motor_timer = 2'((slot / M_OPS) % M_TIMERS);
			r.motor_operator = 1'(slot % M_OPS);
		end else begin
			r.simple_channel = chan;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			simple_taken = '0;
			motor_taken = '0;
			pin_taken = '0;
			grant_queue.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (grant_queue.size() == 0) begin
					report_mismatch("result word with nothing expected", int'(m_axis_tdata), 0);
				end else begin
					want = grant_queue.pop_front();
					if (m_axis_tdata[1:0] !== want.status)
						report_mismatch("status", int'(m_axis_tdata[1:0]), int'(want.status));
					if (m_axis_tuser !== want.driver_used)
						report_mismatch("driver_used", int'(m_axis_tuser), int'(want.driver_used));
					if (m_axis_tdata[4:2] !== want.simple_channel)
						report_mismatch("simple_channel", int'(m_axis_tdata[4:2]),
							int'(want.simple_channel));
					if (m_axis_tdata[5] !== want.motor_unit)
						report_mismatch("motor_unit", int'(m_axis_tdata[5]), int'(want.motor_unit));
					if (m_axis_tdata[7:6] !== want.motor_timer)
						report_mismatch("motor_timer", int'(m_axis_tdata[7:6]),
							int'(want.motor_timer));
					if (m_axis_tdata[8] !== want.motor_operator)
						report_mismatch("motor_operator", int'(m_axis_tdata[8]),
							int'(want.motor_operator));
					if (m_axis_tdata[15:9] !== 7'd0)
						report_mismatch("padding", int'(m_axis_tdata[15:9]), 0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				grant_queue.push_back(decide_grant(s_axis_tdata[5:0], s_axis_tuser,
					s_axis_tdata[6], s_axis_tdata[14:7], s_axis_tdata[16:15],
					s_axis_tdata[18:17], s_axis_tdata[19]));
			end
			outstanding <= grant_queue.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the PWM channel allocator testbench: clock, reset, request stimulus and result drain.
// Depends on pwm_ca_pkg, pwm_channel_allocator and pwm_grant_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 60000;
	localparam int RANDOM_ITEMS = 750;
	localparam int LONG_HOLD = 60;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	int fail_count;
	int outstanding;
	int cycle_count = 0;
	bit sender_eager = 1'b0;

	pwm_channel_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	pwm_grant_checker grant_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_request(input logic [5:0] pin, input logic [1:0] mode,
			input logic psv, input logic [7:0] psc, input logic [1:0] unit,
			input logic [1:0] timer, input logic op);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {4'b0000, op, timer, unit, psc, psv, pin};
		s_axis_tuser <= mode;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : drain_results
		int gap;
		int words_taken;
		words_taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = ((words_taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
			if (words_taken == 40)
				gap = LONG_HOLD;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			words_taken++;
		end
	end

	initial begin : make_requests
		int i;
		logic [5:0] pin;
		logic [7:0] psc;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		send_request(6'd0, pwm_ca_pkg::MODE_SIMPLE, 1'b1, 8'd5, 2'd0, 2'd0, 1'b0);
		send_request(6'd0, pwm_ca_pkg::MODE_MOTOR, 1'b0, 8'd0, 2'd0, 2'd0, 1'b0);
		send_request(6'd1, pwm_ca_pkg::MODE_SIMPLE, 1'b1, 8'd5, 2'd0, 2'd0, 1'b0);
		send_request(6'd2, pwm_ca_pkg::MODE_SIMPLE, 1'b1, 8'd255, 2'd3, 2'd3, 1'b1);
		send_request(6'd3, pwm_ca_pkg::MODE_SIMPLE, 1'b0, 8'd7, 2'd0, 2'd0, 1'b0);
		send_request(6'd4, pwm_ca_pkg::MODE_MOTOR, 1'b0, 8'd0, 2'd1, 2'd2, 1'b1);
		send_request(6'd5, pwm_ca_pkg::MODE_MOTOR, 1'b1, 8'd3, 2'd1, 2'd2, 1'b1);
		send_request(6'd6, pwm_ca_pkg::MODE_MOTOR, 1'b0, 8'd0, 2'd3, 2'd0, 1'b0);
		send_request(6'd7, pwm_ca_pkg::MODE_MOTOR, 1'b0, 8'd0, 2'd0, 2'd3, 1'b1);
		send_request(6'd63, MODE_SPARE, 1'b1, 8'd7, 2'd0, 2'd0, 1'b0);
		send_request(6'd62, pwm_ca_pkg::MODE_AUTO, 1'b1, 8'd7, 2'd0, 2'd0, 1'b0);
		send_request(6'd8, pwm_ca_pkg::MODE_AUTO, 1'b1, 8'd8, 2'd0, 2'd0, 1'b0);
		send_request(6'd9, pwm_ca_pkg::MODE_AUTO, 1'b0, 8'd0, 2'd0, 2'd0, 1'b0);
		send_request(6'd10, pwm_ca_pkg::MODE_SIMPLE, 1'b1, 8'd0, 2'd0, 2'd0, 1'b0);
		send_request(6'd10, pwm_ca_pkg::MODE_AUTO, 1'b0, 8'd0, 2'd0, 2'd0, 1'b0);
		send_request(6'd11, pwm_ca_pkg::MODE_AUTO, 1'b1, 8'd2, 2'd1, 2'd0, 1'b0);
		send_request(6'd63, pwm_ca_pkg::MODE_SIMPLE, 1'b0, 8'd0, 2'd0, 2'd0, 1'b0);
		send_request(6'd12, MODE_SPARE, 1'b0, 8'd0, 2'd0, 2'd2, 1'b1);
		send_request(6'd13, pwm_ca_pkg::MODE_MOTOR, 1'b0, 8'd0, 2'd2, 2'd1, 1'b0);
		wait_drained();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			sender_eager = ((i / 60) % 3 == 1);
			if (i == 400)
				wait_drained();
			pin = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 13)) : 6'($urandom);
			psc = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
			send_request(pin, 2'($urandom), 1'($urandom), psc, 2'($urandom),
				2'($urandom), 1'($urandom));
		end
		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
